### hdl/kmle_pkg.sv
// Package for the key matrix layer event generator.
// Holds matrix geometry, hold-state and opcode codes, beat types and index helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kmle_pkg;

    // Matrix geometry
    localparam int ROWS  = 8;
    localparam int COLS  = 16;
    localparam int KEYS  = ROWS * COLS;
    localparam int ROW_W = 3;
    localparam int COL_W = 4;
    localparam int IDX_W = $clog2(KEYS);
    localparam int MAP_W = IDX_W + 1;      // layer bit above the key index

    // Field widths
    localparam int CODE_W  = 8;
    localparam int ENTRY_W = 2 * CODE_W;   // modifier mask high, usage code low
    localparam int HOLD_W  = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Per-key hold state codes
    localparam logic [HOLD_W-1:0] HOLD_IDLE = 2'd0;
    localparam logic [HOLD_W-1:0] HOLD_BASE = 2'd1;
    localparam logic [HOLD_W-1:0] HOLD_ALT  = 2'd2;

    // Input opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FN_ROW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FN_COL = 1'b1;

    // Reset values of the configuration registers
    localparam logic [ROW_W-1:0] FN_ROW_RST = 3'd4;
    localparam logic [COL_W-1:0] FN_COL_RST = 4'd0;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } t_state;

    // One output event
    typedef struct packed {
        logic              is_modifier;
        logic [CODE_W-1:0] code;
        logic              is_down;
        logic              last;
    } t_evt;

    // Hold-state memory write request
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [HOLD_W-1:0] data;
    } t_hold_wr;

    // Keymap memory write request
    typedef struct packed {
        logic               en;
        logic [MAP_W-1:0]   addr;
        logic [ENTRY_W-1:0] data;
    } t_map_wr;

    function automatic logic in_matrix(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        in_matrix = (32'(row) < ROWS) && (32'(col) < COLS);
    endfunction

    function automatic logic [IDX_W-1:0] key_index(logic [ROW_W-1:0] row,
                                                   logic [COL_W-1:0] col);
        key_index = IDX_W'(row) * IDX_W'(COLS) + IDX_W'(col);
    endfunction

endpackage

`default_nettype wire

### hdl/kmle_hold_mem.sv
// Per-key hold-state memory: one write port, two registered read ports.
// Entries never written since reset read as idle through a valid bit per key.
// Depends on kmle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmle_hold_mem
    import kmle_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_hold_wr          i_wr,
    input  wire logic              i_rd_en,
    input  wire logic [IDX_W-1:0]  i_rd_addr_a,
    input  wire logic [IDX_W-1:0]  i_rd_addr_b,
    output logic      [HOLD_W-1:0] o_rd_data_a,
    output logic      [HOLD_W-1:0] o_rd_data_b
);

    logic [HOLD_W-1:0] r_mem [KEYS];
    logic [KEYS-1:0]   r_vld;
    logic [HOLD_W-1:0] r_rd_a;
    logic [HOLD_W-1:0] r_rd_b;
    logic              r_vld_a;
    logic              r_vld_b;

    // Storage array and read data
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    // Valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_vld_a <= r_vld[i_rd_addr_a];
                r_vld_b <= r_vld[i_rd_addr_b];
            end
        end
    end

    assign o_rd_data_a = r_vld_a ? r_rd_a : HOLD_IDLE;
    assign o_rd_data_b = r_vld_b ? r_rd_b : HOLD_IDLE;

endmodule

`default_nettype wire

### hdl/kmle_map_mem.sv
// Keymap memory for both layers, addressed by {layer, key}.
// One write port; reads the base and alternate entries of a key together.
// Depends on kmle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmle_map_mem
    import kmle_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_map_wr            i_wr,
    input  wire logic               i_rd_en,
    input  wire logic [IDX_W-1:0]   i_rd_addr,
    output logic      [ENTRY_W-1:0] o_base,
    output logic      [ENTRY_W-1:0] o_alt
);

    localparam int DEPTH = 2 * KEYS;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    logic [ENTRY_W-1:0] r_rd_base;
    logic [ENTRY_W-1:0] r_rd_alt;
    logic               r_vld_base;
    logic               r_vld_alt;
    logic [MAP_W-1:0]   addr_base;
    logic [MAP_W-1:0]   addr_alt;

    assign addr_base = {1'b0, i_rd_addr};
    assign addr_alt  = {1'b1, i_rd_addr};

    // Storage array and read data
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_base <= r_mem[addr_base];
            r_rd_alt  <= r_mem[addr_alt];
        end
    end

    // Valid bits: unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_vld_base <= 1'b0;
            r_vld_alt  <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_vld_base <= r_vld[addr_base];
                r_vld_alt  <= r_vld[addr_alt];
            end
        end
    end

    assign o_base = r_vld_base ? r_rd_base : '0;
    assign o_alt  = r_vld_alt  ? r_rd_alt  : '0;

endmodule

`default_nettype wire

### hdl/kmle_evt_queue.sv
// Two-entry event queue driving the master stream side.
// Loaded with up to two events at once, drained one beat per cycle while the receiver is ready.
// Depends on kmle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmle_evt_queue
    import kmle_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire logic [1:0]             i_count,
    input  wire t_evt                   i_ev0,
    input  wire t_evt                   i_ev1,
    output logic                        o_can_load,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] event_code, [8] is_down
    output logic                        m_axis_tuser,   // [0] is_modifier
    output logic                        m_axis_tlast
);

    t_evt       r_q0;
    t_evt       r_q1;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop        = m_axis_tvalid && m_axis_tready;
    // Loading is allowed once the queue is empty after this cycle's beat
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Entries
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q0 <= i_ev0;
            r_q1 <= i_ev1;
        end else if (pop) begin
            r_q0 <= r_q1;
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {(OUT_TDATA_W - CODE_W - 1)'(0), r_q0.is_down, r_q0.code};
    assign m_axis_tuser  = r_q0.is_modifier;
    assign m_axis_tlast  = r_q0.last;

endmodule

`default_nettype wire

### hdl/key_matrix_layer_event_gen_unit.sv
// Key matrix event generator with a function layer: top level.
// Sequencer, configuration registers, hold-state and keymap memories, event queue.
// Depends on kmle_pkg, kmle_hold_mem, kmle_map_mem, kmle_evt_queue.
//
// Usage:
//   s_axis carries one beat per key sample (tuser = 0) or keymap write
//   (tuser = 1). m_axis returns the press/release events a sample causes:
//   zero, one or two beats (modifier event first), tlast on the final one.
//   Keymap writes and repeated levels produce no beats.
//   The cfg channel writes the function key row (index 0) and column
//   (index 1); it is always ready and should be used while the block is idle.
// Timing:
//   A beat is accepted in one cycle and evaluated in the next; a new beat
//   is accepted only once that evaluation completes. The first event is on
//   m_axis in the cycle after evaluation. Evaluation waits until the
//   two-entry event queue can take its events; the queue drains one beat
//   per cycle while the receiver is ready.
// Reset:
//   All keys idle, both keymaps zero (valid bits clear at once, no sweep),
//   function key at row 4, column 0. A stalled receiver holds the queue;
//   an item with events then waits in evaluation until it drains, blocking input.
`timescale 1ns / 1ps
`default_nettype none

module key_matrix_layer_event_gen_unit
    import kmle_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Configuration write channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [2:0] key_row, [6:3] key_col, [7] pressed, [8] map_layer,
    // [16:9] key_code, [24:17] modifier_mask, [31:25] zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   s_axis_tuser,   // [0] opcode
    // Event stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] event_code, [8] is_down
    output logic                        m_axis_tuser,   // [0] is_modifier
    output logic                        m_axis_tlast
);

    t_state r_state;
    t_state n_state;

    logic [ROW_W-1:0] r_fn_row;
    logic [COL_W-1:0] r_fn_col;

    // Captured item
    logic              r_opcode;
    logic              r_in_ok;
    logic [IDX_W-1:0]  r_idx;
    logic              r_pressed;
    logic              r_layer;
    logic [CODE_W-1:0] r_code;
    logic [CODE_W-1:0] r_mod;

    // Input field unpack
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;
    logic              in_acc;

    assign in_row = s_axis_tdata[ROW_W-1:0];
    assign in_col = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Memory interfaces
    t_hold_wr           hold_wr;
    t_map_wr            map_wr;
    logic [HOLD_W-1:0]  hold_key;
    logic [HOLD_W-1:0]  hold_fn;
    logic [ENTRY_W-1:0] ent_base;
    logic [ENTRY_W-1:0] ent_alt;

    // Evaluation
    logic               fn_held;
    logic               emit;
    logic [ENTRY_W-1:0] entry;
    logic               ev_down;
    logic [CODE_W-1:0]  ev_mod;
    logic [CODE_W-1:0]  ev_code;
    logic [1:0]         ev_cnt;
    t_evt               ev0;
    t_evt               ev1;
    logic               q_can_load;
    logic               eval_go;
    logic               q_load;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn_row <= FN_ROW_RST;
            r_fn_col <= FN_COL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FN_ROW: r_fn_row <= i_cfg_data[ROW_W-1:0];
                CFG_FN_COL: r_fn_col <= i_cfg_data[COL_W-1:0];
                default:    ;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_opcode  <= s_axis_tuser;
            r_in_ok   <= in_matrix(in_row, in_col);
            r_idx     <= key_index(in_row, in_col);
            r_pressed <= s_axis_tdata[7];
            r_layer   <= s_axis_tdata[8];
            r_code    <= s_axis_tdata[16:9];
            r_mod     <= s_axis_tdata[24:17];
        end
    end

    // State memories, read at acceptance
    kmle_hold_mem u_hold_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (hold_wr),
        .i_rd_en     (in_acc),
        .i_rd_addr_a (key_index(in_row, in_col)),
        .i_rd_addr_b (key_index(r_fn_row, r_fn_col)),
        .o_rd_data_a (hold_key),
        .o_rd_data_b (hold_fn)
    );

    kmle_map_mem u_map_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (map_wr),
        .i_rd_en   (in_acc),
        .i_rd_addr (key_index(in_row, in_col)),
        .o_base    (ent_base),
        .o_alt     (ent_alt)
    );

    // Press/release decision and entry selection
    always_comb begin
        fn_held = in_matrix(r_fn_row, r_fn_col) && (hold_fn != HOLD_IDLE);
        emit    = 1'b0;
        entry   = ent_base;
        ev_down = r_pressed;
        hold_wr = '{en: 1'b0, addr: r_idx, data: HOLD_IDLE};
        if (r_in_ok && (r_opcode == OP_SAMPLE)) begin
            if (r_pressed && (hold_key == HOLD_IDLE)) begin
                emit         = 1'b1;
                hold_wr.en   = 1'b1;
                hold_wr.data = fn_held ? HOLD_ALT : HOLD_BASE;
                entry        = fn_held ? ent_alt : ent_base;
            end else if (!r_pressed && (hold_key != HOLD_IDLE)) begin
                emit         = 1'b1;
                hold_wr.en   = 1'b1;
                hold_wr.data = HOLD_IDLE;
                entry        = (hold_key == HOLD_BASE) ? ent_base : ent_alt;
            end
        end
        // memory writes land only when the evaluation completes
        hold_wr.en = hold_wr.en && eval_go && (r_state == ST_EVAL);
    end

    // Event build: modifier first, then key
    always_comb begin
        ev_mod  = entry[ENTRY_W-1:CODE_W];
        ev_code = entry[CODE_W-1:0];
        ev_cnt  = emit ? (2'((ev_mod != '0)) + 2'((ev_code != '0))) : 2'd0;
        ev1     = '{is_modifier: 1'b0, code: ev_code, is_down: ev_down, last: 1'b1};
        if (ev_mod != '0) begin
            ev0 = '{is_modifier: 1'b1, code: ev_mod, is_down: ev_down,
                    last: (ev_code == '0)};
        end else begin
            ev0 = ev1;
        end
    end

    assign eval_go = (ev_cnt == 2'd0) || q_can_load;
    assign q_load  = (r_state == ST_EVAL) && eval_go && (ev_cnt != 2'd0);

    // Keymap write
    always_comb begin
        map_wr.en   = (r_state == ST_EVAL) && r_in_ok && (r_opcode == OP_WRITE);
        map_wr.addr = {r_layer, r_idx};
        map_wr.data = {r_mod, r_code};
    end

    kmle_evt_queue u_evt_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (q_load),
        .i_count       (ev_cnt),
        .i_ev0         (ev0),
        .i_ev1         (ev1),
        .o_can_load    (q_can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc) begin
                n_state = ST_EVAL;
            end
            ST_EVAL: if (eval_go) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        o_cfg_ready   = 1'b1;
    end

    // Checks
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input accepted on two consecutive cycles");

    a_pair_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("second event of a pair not queued");

    a_hold_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hold_wr.en |-> (hold_wr.data == HOLD_IDLE || hold_wr.data == HOLD_BASE ||
                        hold_wr.data == HOLD_ALT))
        else $error("illegal hold state written");

    a_no_dual_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(hold_wr.en && map_wr.en))
        else $error("sample and keymap write in the same evaluation");

endmodule

`default_nettype wire
